// ===== hdl/pre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pre_pkg
// Shared constants and types for the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

  localparam int unsigned MAX_RUN_DEF     = 32;
  localparam int unsigned OFFSET_BITS_DEF = 32;

  localparam int unsigned MIN_RUN_W = 6;
  localparam int unsigned COL_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned ROFF_W    = 32;

  localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST      = 6'd4;
  localparam logic [COL_W-1:0]     LINE_LIMIT_RST   = 8'd78;
  localparam logic [COL_W-1:0]     WRAP_COLUMN_RST  = 8'd11;
  localparam logic [COL_W-1:0]     PREFIX_WIDTH_RST = 8'd10;

  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RUN      = 2'd0,
    CFG_LINE_LIMIT   = 2'd1,
    CFG_WRAP_COLUMN  = 2'd2,
    CFG_PREFIX_WIDTH = 2'd3
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    REC_START = 3'd0,
    REC_CHAR  = 3'd1,
    REC_END   = 3'd2,
    REC_WRAP  = 3'd3,
    REC_EOS   = 3'd4
  } rec_kind_t;

endpackage
`default_nettype wire

// ===== hdl/printable_run_extractor_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// printable_run_extractor_core
// Finds runs of printable bytes of at least min_run characters (clamped to 1..MAX_RUN) and emits
// start, character, wrap, end and end-of-stream records.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/ready   | kind, data_byte
//  out     | output    | out_valid/ready  | record_kind, char_value, run_offset, last
//  cfg     | input     | cfg_we           | cfg_index, cfg_wdata
//
//  The block takes an item only while idle, then sends its records, one per
//  cycle while out_ready is high, and takes no further item until the last
//  record is in the output register. A run start sends a start record and
//  then replays the saved characters of the run. Replay reads the save
//  buffer one entry a cycle through its read port while the output is not stalled.
//  Reset (synchronous, rst_n low) clears control state and loads defaults.
// ----------------------------------------------------------------------------
module printable_run_extractor_core #(
  parameter int unsigned MAX_RUN     = pre_pkg::MAX_RUN_DEF,
  parameter int unsigned OFFSET_BITS = pre_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_kind,
  input  wire logic [pre_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pre_pkg::KIND_W-1:0]         out_record_kind,
  output logic [pre_pkg::CHAR_W-1:0]         out_char_value,
  output logic [pre_pkg::ROFF_W-1:0]         out_run_offset,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [pre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pre_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int unsigned RC_W = $clog2(MAX_RUN + 1);
  localparam int unsigned AW   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int unsigned COL_W = pre_pkg::COL_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_END   = 8'b0000_0010,
    S_EOS   = 8'b0000_0100,
    S_WRAP  = 8'b0000_1000,
    S_CHAR  = 8'b0001_0000,
    S_START = 8'b0010_0000,
    S_RPL   = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [pre_pkg::MIN_RUN_W-1:0] min_run_r;
  logic [COL_W-1:0]              line_limit_r;
  logic [COL_W-1:0]              wrap_column_r;
  logic [COL_W-1:0]              prefix_width_r;

  logic [RC_W-1:0]        run_count_r;
  logic [COL_W-1:0]       column_count_r;
  logic [OFFSET_BITS-1:0] byte_offset_r;
  logic [OFFSET_BITS-1:0] start_off_r;
  logic                   item_eos_r;
  logic [pre_pkg::CHAR_W-1:0] char_r;
  logic [AW-1:0]          rpl_idx_r;
  logic [AW-1:0]          rpl_last_r;

  logic [pre_pkg::CHAR_W-1:0] save_mem [MAX_RUN];
  logic [pre_pkg::CHAR_W-1:0] rd_data_r;

  logic                   out_valid_r;
  logic [pre_pkg::KIND_W-1:0] out_kind_r;
  logic [pre_pkg::CHAR_W-1:0] out_char_r;
  logic [pre_pkg::ROFF_W-1:0] out_off_r;
  logic                   out_last_r;

  logic            accept;
  logic            slot_free;
  logic            emit;
  logic [RC_W-1:0] m_eff;
  logic            printable;
  logic            run_open;
  logic [RC_W-1:0] run_inc;
  logic            reach;
  logic [8:0]      col_sum;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            rpl_done;
  logic [63:0]     start_ext;

  pre_pkg::rec_kind_t         rec_kind;
  logic [pre_pkg::CHAR_W-1:0] rec_char;
  logic                       rec_last;

  always_comb begin
    if (min_run_r == '0) begin
      m_eff = RC_W'(1);
    end else if (32'(min_run_r) > MAX_RUN) begin
      m_eff = RC_W'(MAX_RUN);
    end else begin
      m_eff = RC_W'(min_run_r);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r != S_IDLE) && slot_free;
  assign printable = (in_data_byte >= pre_pkg::PRINT_LO) && (in_data_byte <= pre_pkg::PRINT_HI);
  assign run_open  = (run_count_r >= m_eff);
  assign run_inc   = run_count_r + RC_W'(1);
  assign reach     = (run_inc >= m_eff);
  assign col_sum   = 9'(m_eff) + 9'(prefix_width_r);
  assign rpl_done  = (rpl_idx_r == rpl_last_r);
  assign start_ext = 64'(start_off_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r      <= pre_pkg::MIN_RUN_RST;
      line_limit_r   <= pre_pkg::LINE_LIMIT_RST;
      wrap_column_r  <= pre_pkg::WRAP_COLUMN_RST;
      prefix_width_r <= pre_pkg::PREFIX_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (pre_pkg::cfg_idx_t'(cfg_index))
        pre_pkg::CFG_MIN_RUN:      min_run_r      <= cfg_wdata[pre_pkg::MIN_RUN_W-1:0];
        pre_pkg::CFG_LINE_LIMIT:   line_limit_r   <= cfg_wdata;
        pre_pkg::CFG_WRAP_COLUMN:  wrap_column_r  <= cfg_wdata;
        pre_pkg::CFG_PREFIX_WIDTH: prefix_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      if (in_kind) begin
        state_nxt = run_open ? S_END : S_EOS;
      end else if (run_open) begin
        if (!printable) begin
          state_nxt = S_END;
        end else if (column_count_r > line_limit_r) begin
          state_nxt = S_WRAP;
        end else begin
          state_nxt = S_CHAR;
        end
      end else if (printable && reach) begin
        state_nxt = S_START;
      end
    end else if (emit) begin
      unique case (state_r)
        S_END:   state_nxt = item_eos_r ? S_EOS : S_IDLE;
        S_EOS:   state_nxt = S_IDLE;
        S_WRAP:  state_nxt = S_CHAR;
        S_CHAR:  state_nxt = S_IDLE;
        S_START: state_nxt = S_RPL;
        S_RPL:   state_nxt = rpl_done ? S_IDLE : S_RPL;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      run_count_r    <= '0;
      column_count_r <= '0;
      byte_offset_r  <= '0;
      rpl_idx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_kind) begin
          run_count_r   <= '0;
          byte_offset_r <= '0;
        end else begin
          byte_offset_r <= byte_offset_r + OFFSET_BITS'(1);
          if (run_open) begin
            if (!printable) begin
              run_count_r <= '0;
            end else if (column_count_r > line_limit_r) begin
              column_count_r <= wrap_column_r;
            end else if (column_count_r != {COL_W{1'b1}}) begin
              column_count_r <= column_count_r + COL_W'(1);
            end
          end else if (!printable) begin
            run_count_r <= '0;
          end else begin
            run_count_r <= run_inc;
            if (reach) begin
              column_count_r <= (col_sum > 9'd255) ? {COL_W{1'b1}} : col_sum[COL_W-1:0];
            end
          end
        end
      end
      if (emit && (state_r == S_START)) begin
        rpl_idx_r <= '0;
      end else if (emit && (state_r == S_RPL)) begin
        rpl_idx_r <= rpl_idx_r + AW'(1);
      end
    end
  end

  // item payload held for the record sequence
  always_ff @(posedge clk) begin
    if (accept) begin
      item_eos_r  <= in_kind;
      char_r      <= in_data_byte[pre_pkg::CHAR_W-1:0];
      start_off_r <= byte_offset_r - OFFSET_BITS'(m_eff) + OFFSET_BITS'(1);
      rpl_last_r  <= AW'(m_eff - RC_W'(1));
    end
  end

  // save buffer
  assign rd_en   = emit && ((state_r == S_START) || ((state_r == S_RPL) && !rpl_done));
  assign rd_addr = (state_r == S_START) ? '0 : rpl_idx_r + AW'(1);

  always_ff @(posedge clk) begin
    if (accept && !in_kind && printable && !run_open) begin
      save_mem[run_count_r[AW-1:0]] <= in_data_byte[pre_pkg::CHAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= save_mem[rd_addr];
    end
  end

  // record build
  always_comb begin
    rec_kind = pre_pkg::REC_EOS;
    rec_char = '0;
    rec_last = 1'b1;
    unique case (state_r)
      S_END: begin
        rec_kind = pre_pkg::REC_END;
        rec_last = !item_eos_r;
      end
      S_WRAP: begin
        rec_kind = pre_pkg::REC_WRAP;
        rec_last = 1'b0;
      end
      S_CHAR: begin
        rec_kind = pre_pkg::REC_CHAR;
        rec_char = char_r;
      end
      S_START: begin
        rec_kind = pre_pkg::REC_START;
        rec_last = 1'b0;
      end
      S_RPL: begin
        rec_kind = pre_pkg::REC_CHAR;
        rec_char = rd_data_r;
        rec_last = rpl_done;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= rec_kind;
      out_char_r <= rec_char;
      out_off_r  <= (state_r == S_START) ? start_ext[pre_pkg::ROFF_W-1:0] : '0;
      out_last_r <= rec_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_record_kind = out_kind_r;
  assign out_char_value  = out_char_r;
  assign out_run_offset  = out_off_r;
  assign out_last        = out_last_r;

  a_run_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(run_count_r) <= MAX_RUN)
    else $error("run count beyond buffer depth");

  a_rpl_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RPL) |-> (rpl_idx_r <= rpl_last_r))
    else $error("replay index past last saved entry");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind) |=> (run_count_r == '0) && (byte_offset_r == '0))
    else $error("end of stream did not clear run state");

  a_start_then_replay: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (state_r == S_START)) |=> (state_r == S_RPL))
    else $error("start record not followed by replay");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && (state_r != S_IDLE)) |=> $stable(state_r))
    else $error("sequencer moved while output stalled");

endmodule
`default_nettype wire
